// ===== design/ctf_pkg.sv =====
// ----------------------------------------------------------------------------
// ctf_pkg
// Shared constants, the arctangent table and helpers for the tilt filter.
// ----------------------------------------------------------------------------
package ctf_pkg;

    // Default build parameters.
    localparam int CORDIC_STEPS_DEF    = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 16;

    // Fixed field widths.
    localparam int SAMPLE_W    = 16;
    localparam int ANGLE_OUT_W = 25;
    localparam int WEIGHT_W    = 17;
    localparam int GAIN_W      = 32;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 32;

    // Register indexes on the configuration channel.
    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_WEIGHT   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_STEP_GAIN = 1'd1;

    localparam logic [WEIGHT_W-1:0] BLEND_WEIGHT_RST   = 17'd64225;
    localparam logic [GAIN_W-1:0]   GYRO_STEP_GAIN_RST = 32'd327868;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE         = 17'd65536;

    // CORDIC datapath width and accelerometer prescale.
    localparam int CORDIC_XW = 34;
    localparam int ACC_SHIFT = 14;

    // 1/K in Q.31, applied to the magnitude pass result.
    localparam logic [30:0] INV_GAIN_Q31 = 31'd1304065748;

    localparam int TABLE_LEN = 24;
    localparam logic [29:0] ATAN_DEG_Q24 [TABLE_LEN] = '{
        30'd754974720, 30'd445687602, 30'd235489088, 30'd119537938,
        30'd60000934,  30'd30029717,  30'd15018523,  30'd7509720,
        30'd3754917,   30'd1877466,   30'd938734,    30'd469367,
        30'd234684,    30'd117342,    30'd58671,     30'd29335,
        30'd14668,     30'd7334,      30'd3667,      30'd1833,
        30'd917,       30'd458,       30'd229,       30'd115
    };

    // Arctangent of 2^-i in degrees, rounded half up to frac fraction bits.
    function automatic logic [31:0] atan_entry(input logic [4:0] i, input int frac);
        logic [31:0] t;
        logic [31:0] r;
        t = 32'(ATAN_DEG_Q24[i]);
        if (frac >= 24) begin
            r = t;
        end else begin
            r = (t + (32'd1 << (23 - frac))) >> (24 - frac);
        end
        return r;
    endfunction

endpackage

// ===== design/ctf_mul.sv =====
// ----------------------------------------------------------------------------
// ctf_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module ctf_mul #(
    parameter int AW = 35,
    parameter int BW = 34
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic signed [AW-1:0]     a,
    input  logic signed [BW-1:0]     b,
    output logic signed [AW+BW-1:0]  p_reg
);

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= a * b;
        end
    end

endmodule

// ===== design/ctf_cordic.sv =====
// ----------------------------------------------------------------------------
// ctf_cordic
// Vectoring CORDIC that performs one micro-rotation per clock cycle.
// ----------------------------------------------------------------------------
module ctf_cordic
    import ctf_pkg::*;
#(
    parameter int STEPS = CORDIC_STEPS_DEF,
    parameter int FRAC  = ANGLE_FRAC_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic signed [CORDIC_XW-1:0] x_init,
    input  logic signed [CORDIC_XW-1:0] y_init,
    output logic                        done_reg,
    output logic signed [CORDIC_XW-1:0] x_reg,
    output logic signed [FRAC+9:0]      z_reg
);

    localparam int ZW = FRAC + 10;
    localparam int SW = $clog2(STEPS + 1);
    localparam int IW = $clog2(STEPS);

    logic signed [CORDIC_XW-1:0] y_reg;
    logic [SW-1:0]               step_reg;
    logic                        run_reg;

    logic [IW-1:0]               idx;
    logic signed [CORDIC_XW-1:0] xs;
    logic signed [CORDIC_XW-1:0] ys;
    logic signed [ZW-1:0]        tab;

    assign idx = step_reg[IW-1:0];
    assign xs  = x_reg >>> idx;
    assign ys  = y_reg >>> idx;
    assign tab = ZW'(atan_entry(5'(idx), FRAC));

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg <= x_init;
            y_reg <= y_init;
            z_reg <= '0;
        end else if (run_reg) begin
            if (y_reg > 0) begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + tab;
            end else begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - tab;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg  <= 1'b1;
                step_reg <= '0;
            end else if (run_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == SW'(STEPS - 1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== design/complementary_tilt_filter.sv =====
// ----------------------------------------------------------------------------
// complementary_tilt_filter
// Pitch and roll complementary filter for one IMU sample stream.
// ----------------------------------------------------------------------------
// Each accepted word is one IMU sample. The block forms the accelerometer
// pitch and roll angles with one shared vectoring CORDIC (a magnitude pass and
// an angle pass per axis, one micro-rotation per cycle), then blends each with
// the gyro-integrated previous estimate on one shared multiplier. The block
// takes one sample at a time and is through with it before it takes the next.
// An axis with a zero numerator or a zero magnitude skips its two passes.
// s_tready is high only while the block is idle; the finished result waits in
// an output register, so a new sample can be taken while the previous result
// is still unread.
// Angles are signed degrees with ANGLE_FRAC_BITS fraction bits, saturated to
// plus or minus 180 degrees, and shown in 25-bit fields.
// ----------------------------------------------------------------------------
module complementary_tilt_filter
    import ctf_pkg::*;
#(
    parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF,
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input words.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // accel_x [15:0], accel_y [31:16], accel_z [47:32], rate_x [63:48],
    // rate_y [79:64]
    input  logic [79:0]           s_tdata,
    // Result words.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // pitch_angle [24:0], roll_angle [49:25], zero [55:50]
    output logic [55:0]           m_tdata,
    // Configuration writes.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int F   = ANGLE_FRAC_BITS;
    localparam int XW  = CORDIC_XW;
    localparam int ZW  = F + 10;          // accelerometer angle
    localparam int EW  = F + 9;           // saturated estimate
    localparam int DW  = F + 18;          // gyro increment
    localparam int PW  = F + 19;          // predicted angle
    localparam int AW  = (PW > XW) ? PW : XW;
    localparam int BW  = 34;
    localparam int PRW = AW + BW;
    localparam int SUW = PRW + 1;

    localparam longint LIM_L  = longint'(180) << F;
    localparam longint NINE_L = longint'(90) << F;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SETUP = 4'd1;
    localparam logic [3:0] S_P1    = 4'd2;
    localparam logic [3:0] S_MUL   = 4'd3;
    localparam logic [3:0] S_MAG   = 4'd4;
    localparam logic [3:0] S_P2    = 4'd5;
    localparam logic [3:0] S_GMUL  = 4'd6;
    localparam logic [3:0] S_PRED  = 4'd7;
    localparam logic [3:0] S_AMUL  = 4'd8;
    localparam logic [3:0] S_BMUL  = 4'd9;
    localparam logic [3:0] S_SUM   = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    // Control state.
    logic [3:0] state_reg, state_next;
    logic       ch_reg, ch_next;     // 0 works on pitch, 1 on roll
    logic       m_tvalid_reg;
    logic [WEIGHT_W-1:0] weight_reg;
    logic [GAIN_W-1:0]   gain_reg;
    logic signed [EW-1:0] pitch_est_reg, roll_est_reg;

    // Payload registers.
    logic signed [SAMPLE_W-1:0] ax_reg, ay_reg, az_reg, gx_reg, gy_reg;
    logic signed [ZW-1:0]       pitch_acc_reg, roll_acc_reg;
    logic signed [PW-1:0]       pred_reg;
    logic signed [PRW-1:0]      sum_a_reg;
    logic [ANGLE_OUT_W-1:0]     out_pitch_reg, out_roll_reg;

    // Per-channel operand selection.
    logic signed [SAMPLE_W-1:0] num_sel, oth_sel, rate_sel;
    logic signed [EW-1:0]       est_sel;
    logic signed [ZW-1:0]       acc_sel;
    logic signed [SAMPLE_W:0]   oth_abs, z_abs;

    // CORDIC and multiplier hookup.
    logic                  cor_start;
    logic signed [XW-1:0]  cor_x_init, cor_y_init, cor_x;
    logic signed [ZW-1:0]  cor_z;
    logic                  cor_done;
    logic                  mul_en;
    logic signed [AW-1:0]  mul_a;
    logic signed [BW-1:0]  mul_b;
    logic signed [PRW-1:0] prod_reg;

    // Arithmetic around the multiplier.
    logic [WEIGHT_W-1:0]   alpha;
    logic signed [17:0]    alpha_s, beta_s;
    logic signed [PRW-1:0] mag_round, dsum;
    logic signed [XW-1:0]  mag;
    logic signed [DW-1:0]  delta;
    logic signed [SUW-1:0] blend_sum, blend_v, blend_sat;

    ctf_cordic #(
        .STEPS(CORDIC_STEPS),
        .FRAC (ANGLE_FRAC_BITS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cor_start),
        .x_init  (cor_x_init),
        .y_init  (cor_y_init),
        .done_reg(cor_done),
        .x_reg   (cor_x),
        .z_reg   (cor_z)
    );

    ctf_mul #(
        .AW(AW),
        .BW(BW)
    ) u_mul (
        .aclk (aclk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .p_reg(prod_reg)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {6'd0, out_roll_reg, out_pitch_reg};

    // Pitch uses accel_x over the y/z magnitude, roll uses accel_y over x/z.
    assign num_sel  = ch_reg ? ay_reg : ax_reg;
    assign oth_sel  = ch_reg ? ax_reg : ay_reg;
    assign rate_sel = ch_reg ? gx_reg : gy_reg;
    assign est_sel  = ch_reg ? roll_est_reg : pitch_est_reg;
    assign acc_sel  = ch_reg ? roll_acc_reg : pitch_acc_reg;
    assign oth_abs  = oth_sel[SAMPLE_W-1] ? -(SAMPLE_W+1)'(oth_sel) : (SAMPLE_W+1)'(oth_sel);
    assign z_abs    = az_reg[SAMPLE_W-1] ? -(SAMPLE_W+1)'(az_reg) : (SAMPLE_W+1)'(az_reg);

    // A weight above one saturates to pure gyro.
    assign alpha   = (weight_reg > WEIGHT_ONE) ? WEIGHT_ONE : weight_reg;
    assign alpha_s = signed'(18'(alpha));
    assign beta_s  = signed'(18'(WEIGHT_ONE - alpha));

    // Magnitude scaled by 1/K, rounded half up, never negative.
    assign mag_round = (prod_reg + (PRW'(1) <<< 30)) >>> 31;
    assign mag       = (mag_round < 0) ? '0 : XW'(mag_round);

    // Gyro increment rounded half up to the angle format.
    assign dsum  = prod_reg + (PRW'(1) <<< (31 - F));
    assign delta = DW'(dsum >>> (32 - F));

    assign blend_sum = SUW'(sum_a_reg) + SUW'(prod_reg) + SUW'(32768);
    assign blend_v   = blend_sum >>> 16;
    always_comb begin
        if (blend_v > SUW'(LIM_L)) begin
            blend_sat = SUW'(LIM_L);
        end else if (blend_v < -SUW'(LIM_L)) begin
            blend_sat = -SUW'(LIM_L);
        end else begin
            blend_sat = blend_v;
        end
    end

    // CORDIC load: magnitude pass from SETUP, angle pass from MAG.
    always_comb begin
        cor_start  = 1'b0;
        cor_x_init = XW'(oth_abs) <<< ACC_SHIFT;
        cor_y_init = XW'(z_abs) <<< ACC_SHIFT;
        if (state_reg == S_SETUP) begin
            cor_start = (num_sel != 0) && !(oth_sel == 0 && az_reg == 0);
        end else if (state_reg == S_MAG) begin
            cor_start  = 1'b1;
            cor_x_init = mag;
            cor_y_init = XW'(num_sel) <<< ACC_SHIFT;
        end
    end

    // Multiplier operand selection.
    always_comb begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        unique case (state_reg)
            S_MUL: begin
                mul_en = 1'b1;
                mul_a  = AW'(cor_x);
                mul_b  = BW'(INV_GAIN_Q31);
            end
            S_GMUL: begin
                mul_en = 1'b1;
                mul_a  = AW'(rate_sel);
                mul_b  = BW'(gain_reg);
            end
            S_AMUL: begin
                mul_en = 1'b1;
                mul_a  = AW'(pred_reg);
                mul_b  = BW'(alpha_s);
            end
            S_BMUL: begin
                mul_en = 1'b1;
                mul_a  = AW'(acc_sel);
                mul_b  = BW'(beta_s);
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    // Sequencer: angles for both channels, then the blend for both.
    always_comb begin
        state_next = state_reg;
        ch_next    = ch_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_SETUP;
                    ch_next    = 1'b0;
                end
            end
            S_SETUP: begin
                if (cor_start) begin
                    state_next = S_P1;
                end else if (ch_reg) begin
                    state_next = S_GMUL;
                    ch_next    = 1'b0;
                end else begin
                    ch_next = 1'b1;
                end
            end
            S_P1: begin
                if (cor_done) begin
                    state_next = S_MUL;
                end
            end
            S_MUL:  state_next = S_MAG;
            S_MAG:  state_next = S_P2;
            S_P2: begin
                if (cor_done) begin
                    if (ch_reg) begin
                        state_next = S_GMUL;
                        ch_next    = 1'b0;
                    end else begin
                        state_next = S_SETUP;
                        ch_next    = 1'b1;
                    end
                end
            end
            S_GMUL: state_next = S_PRED;
            S_PRED: state_next = S_AMUL;
            S_AMUL: state_next = S_BMUL;
            S_BMUL: state_next = S_SUM;
            S_SUM: begin
                if (ch_reg) begin
                    state_next = S_OUT;
                end else begin
                    state_next = S_GMUL;
                    ch_next    = 1'b1;
                end
            end
            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            ch_reg        <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            weight_reg    <= BLEND_WEIGHT_RST;
            gain_reg      <= GYRO_STEP_GAIN_RST;
            pitch_est_reg <= '0;
            roll_est_reg  <= '0;
        end else begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
            if (cfg_valid) begin
                if (cfg_index == CFG_BLEND_WEIGHT) begin
                    weight_reg <= cfg_data[WEIGHT_W-1:0];
                end else if (cfg_index == CFG_GYRO_STEP_GAIN) begin
                    gain_reg <= cfg_data[GAIN_W-1:0];
                end
            end
            if (state_reg == S_SUM) begin
                if (ch_reg) begin
                    roll_est_reg <= EW'(blend_sat);
                end else begin
                    pitch_est_reg <= EW'(blend_sat);
                end
            end
            if (state_reg == S_OUT && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && s_tvalid) begin
            ax_reg <= s_tdata[15:0];
            ay_reg <= s_tdata[31:16];
            az_reg <= s_tdata[47:32];
            gx_reg <= s_tdata[63:48];
            gy_reg <= s_tdata[79:64];
        end
        if (state_reg == S_SETUP && !cor_start) begin
            // Zero numerator gives zero; zero magnitude gives plus or minus 90.
            if (ch_reg) begin
                roll_acc_reg <= (num_sel == 0) ? '0 :
                    (num_sel > 0 ? ZW'(NINE_L) : -ZW'(NINE_L));
            end else begin
                pitch_acc_reg <= (num_sel == 0) ? '0 :
                    (num_sel > 0 ? ZW'(NINE_L) : -ZW'(NINE_L));
            end
        end
        if (state_reg == S_P2 && cor_done) begin
            if (ch_reg) begin
                roll_acc_reg <= cor_z;
            end else begin
                pitch_acc_reg <= cor_z;
            end
        end
        if (state_reg == S_PRED) begin
            pred_reg <= PW'(est_sel) + PW'(delta);
        end
        if (state_reg == S_BMUL) begin
            sum_a_reg <= prod_reg;
        end
        if (state_reg == S_OUT && (!m_tvalid_reg || m_tready)) begin
            out_pitch_reg <= ANGLE_OUT_W'(pitch_est_reg);
            out_roll_reg  <= ANGLE_OUT_W'(roll_est_reg);
        end
    end

endmodule

// ===== design/ctf_checker.sv =====
// ----------------------------------------------------------------------------
// ctf_checker
// Port-level checks for the tilt filter, bound to the top level.
// ----------------------------------------------------------------------------
module ctf_checker (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [55:0]           m_tdata
);

    // No result word is pending right after reset.
    a_reset_clear: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result word valid after reset");

    // A stalled result word holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result word changed");

    // One sample at a time: the input side closes after a word is taken.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second sample taken while busy");

    // A result needs a sample: none can appear the cycle after one is taken.
    a_no_early: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result word appeared without work");

    // Padding bits of the result word stay zero.
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[55:50] == 6'd0)
        else $error("result padding not zero");

endmodule

bind complementary_tilt_filter ctf_checker u_ctf_checker (.*);
